@@ rtl/dtw_pkg.sv @@
// dtw_pkg: widths, register codes, constants and request types for the
// dds tuning word controller. Used by dtw_div and dds_tuning_word_controller.
// No dependencies.
package dtw_pkg;

  localparam int FREQ_WIDTH     = 34;
  localparam int CLK_WIDTH      = 27;
  localparam int MULT_WIDTH     = 5;
  localparam int DIV_WIDTH      = MULT_WIDTH + CLK_WIDTH;
  localparam int DATA_WIDTH     = 32;
  localparam int ADDR_WIDTH     = 3;
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH = CLK_WIDTH;

  // dividend is freq followed by the fraction bits and one rounding bit
  localparam int QUOT_WIDTH    = DATA_WIDTH + 1;
  localparam int DVD_WIDTH     = FREQ_WIDTH + QUOT_WIDTH;
  localparam int DIV_STEPS     = DVD_WIDTH;
  localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_REF_CLK = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_RF_OVR  = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LO_OVR  = 2'd2;

  localparam logic [ADDR_WIDTH-1:0] REG_PLL = 3'd1;
  localparam logic [ADDR_WIDTH-1:0] REG_FTW = 3'd4;
  localparam logic [2:0]            PLL_CTL = 3'h7;

  localparam logic [FREQ_WIDTH-1:0] BAND_LOW  = FREQ_WIDTH'(64'd600000000);
  localparam logic [FREQ_WIDTH-1:0] BAND_HIGH = FREQ_WIDTH'(64'd850000000);

  localparam logic [MULT_WIDTH-1:0] RF_MULT_BAND = 5'd14;
  localparam logic [MULT_WIDTH-1:0] LO_MULT_BAND = 5'd13;
  localparam logic [MULT_WIDTH-1:0] RF_MULT_DEF  = 5'd20;
  localparam logic [MULT_WIDTH-1:0] LO_MULT_DEF  = 5'd19;

  localparam logic [CLK_WIDTH-1:0] REF_CLK_RST = 27'd36864000;

  typedef struct packed {
    logic                  channel;
    logic [FREQ_WIDTH-1:0] freq_hz;
  } in_req_t;

  typedef struct packed {
    logic                  target_chip;
    logic [ADDR_WIDTH-1:0] reg_addr;
    logic [DATA_WIDTH-1:0] reg_data;
    logic                  last;
  } out_req_t;

endpackage

@@ rtl/dds_tuning_word_controller.sv @@
// dds_tuning_word_controller: top level, multiplier policy, sequencer,
// output register and the shared divider. Depends on dtw_pkg and dtw_div.
//
//   channel   dir  handshake              payload
//   in        in   in_valid_i/in_stall_o   in_req_i  (channel, freq_hz)
//   out       out  out_valid_o/out_stall_i out_req_o (target_chip, reg_addr,
//                                                     reg_data, last)
//   cfg       in   cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// an item passes through idle, the two pll states, the multiplier, start, the divider
// with its registered done and the tuning word write, the divider retiring one quotient
// bit per cycle over FREQ_WIDTH + 33 steps
// in_stall_o is high from acceptance until the tuning word is loaded
// out_stall_i holds the output register and the sequencer waits on it
// reset gives a 36.864 MHz reference, no overrides, multipliers 20 and 19
module dds_tuning_word_controller
  import dtw_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  in_req_t                   in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output out_req_t                  out_req_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RF    = 3'd1;
  localparam logic [2:0] S_LO    = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_TW    = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [CLK_WIDTH-1:0]  ref_clk_q;
  logic [MULT_WIDTH-1:0] rf_ovr_q, lo_ovr_q;
  logic [MULT_WIDTH-1:0] rf_mult_q, rf_mult_d;
  logic [MULT_WIDTH-1:0] lo_mult_q, lo_mult_d;
  logic                  rf_chg_q, rf_chg_d;
  logic                  lo_chg_q, lo_chg_d;
  logic                  chan_q, chan_d;
  logic [FREQ_WIDTH-1:0] freq_q, freq_d;
  logic [DIV_WIDTH-1:0]  dsr_q, dsr_d;
  logic                  out_valid_q, out_valid_d;
  out_req_t              out_req_q, out_req_d;

  logic                  in_acc;
  logic                  out_free;
  logic                  auto_mode, force_mode, in_band;
  logic [MULT_WIDTH-1:0] rf_new, lo_new;
  logic [MULT_WIDTH-1:0] sel_mult;
  logic                  div_start, div_done;
  logic [DATA_WIDTH-1:0] div_word;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // multiplier policy
  assign auto_mode  = !in_req_i.channel && (rf_ovr_q == '0) && (lo_ovr_q == '0);
  assign force_mode = (rf_ovr_q != '0) && (lo_ovr_q != '0);
  assign in_band    = (in_req_i.freq_hz >= BAND_LOW) && (in_req_i.freq_hz <= BAND_HIGH);

  always_comb begin
    rf_new = rf_mult_q;
    lo_new = lo_mult_q;
    if (auto_mode) begin
      rf_new = in_band ? RF_MULT_BAND : RF_MULT_DEF;
      lo_new = in_band ? LO_MULT_BAND : LO_MULT_DEF;
    end else if (force_mode) begin
      rf_new = rf_ovr_q;
      lo_new = lo_ovr_q;
    end
  end

  assign sel_mult  = chan_q ? lo_mult_q : rf_mult_q;
  assign div_start = (state_q == S_START);

  always_comb begin
    state_d     = state_q;
    rf_mult_d   = rf_mult_q;
    lo_mult_d   = lo_mult_q;
    rf_chg_d    = rf_chg_q;
    lo_chg_d    = lo_chg_q;
    chan_d      = chan_q;
    freq_d      = freq_q;
    dsr_d       = dsr_q;
    out_req_d   = out_req_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          chan_d    = in_req_i.channel;
          freq_d    = in_req_i.freq_hz;
          rf_chg_d  = (rf_new != rf_mult_q);
          lo_chg_d  = (lo_new != lo_mult_q);
          rf_mult_d = rf_new;
          lo_mult_d = lo_new;
          state_d   = S_RF;
        end
      end
      S_RF: begin
        if (!rf_chg_q) begin
          state_d = S_LO;
        end else if (out_free) begin
          out_valid_d           = 1'b1;
          out_req_d.target_chip = 1'b0;
          out_req_d.reg_addr    = REG_PLL;
          out_req_d.reg_data    = DATA_WIDTH'({rf_mult_q, PLL_CTL});
          out_req_d.last        = 1'b0;
          state_d               = S_LO;
        end
      end
      S_LO: begin
        if (!lo_chg_q) begin
          state_d = S_MUL;
        end else if (out_free) begin
          out_valid_d           = 1'b1;
          out_req_d.target_chip = 1'b1;
          out_req_d.reg_addr    = REG_PLL;
          out_req_d.reg_data    = DATA_WIDTH'({lo_mult_q, PLL_CTL});
          out_req_d.last        = 1'b0;
          state_d               = S_MUL;
        end
      end
      S_MUL: begin
        dsr_d   = DIV_WIDTH'(sel_mult) * DIV_WIDTH'(ref_clk_q);
        state_d = S_START;
      end
      S_START: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_TW;
        end
      end
      S_TW: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_req_d.target_chip = chan_q;
          out_req_d.reg_addr    = REG_FTW;
          out_req_d.reg_data    = div_word;
          out_req_d.last        = 1'b1;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ref_clk_q   <= REF_CLK_RST;
      rf_ovr_q    <= '0;
      lo_ovr_q    <= '0;
      rf_mult_q   <= RF_MULT_DEF;
      lo_mult_q   <= LO_MULT_DEF;
      rf_chg_q    <= 1'b0;
      lo_chg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rf_mult_q   <= rf_mult_d;
      lo_mult_q   <= lo_mult_d;
      rf_chg_q    <= rf_chg_d;
      lo_chg_q    <= lo_chg_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_REF_CLK: ref_clk_q <= cfg_wdata_i;
          CFG_RF_OVR:  rf_ovr_q  <= cfg_wdata_i[MULT_WIDTH-1:0];
          CFG_LO_OVR:  lo_ovr_q  <= cfg_wdata_i[MULT_WIDTH-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q    <= chan_d;
    freq_q    <= freq_d;
    dsr_q     <= dsr_d;
    out_req_q <= out_req_d;
  end

  dtw_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .freq_i    (freq_q),
    .divisor_i (dsr_q),
    .done_o    (div_done),
    .word_o    (div_word)
  );

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider done outside of divide state");

  a_pll_format: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.reg_addr == REG_PLL
      |-> out_req_o.reg_data[2:0] == PLL_CTL && !out_req_o.last)
    else $error("malformed pll control request");

  a_mult_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_mult_q != '0 && lo_mult_q != '0)
    else $error("pll multiplier is zero");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_RF)
    else $error("accepted request did not start sequencer");

endmodule

@@ rtl/dtw_div.sv @@
// dtw_div: shared restoring divider, one quotient bit per cycle.
// Produces round(frac(freq / divisor) * 2^32) wrapped to 32 bits, or zero for a zero divisor.
// Depends on dtw_pkg.
module dtw_div
  import dtw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [FREQ_WIDTH-1:0] freq_i,
  input  logic [DIV_WIDTH-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] word_o
);

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [DIV_CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [DVD_WIDTH-1:0]     dvd_q, dvd_d;
  logic [DIV_WIDTH-1:0]     dsr_q, dsr_d;
  logic [DIV_WIDTH-1:0]     rem_q, rem_d;
  logic [QUOT_WIDTH-1:0]    quot_q, quot_d;

  logic [DIV_WIDTH:0] trial;
  logic [DIV_WIDTH:0] diff;
  logic               ge;

  assign trial = {rem_q, dvd_q[DVD_WIDTH-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = {freq_i, {QUOT_WIDTH{1'b0}}};
      dsr_d  = divisor_i;
      rem_d  = '0;
      quot_d = '0;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[DVD_WIDTH-2:0], 1'b0};
      rem_d  = ge ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
      quot_d = {quot_q[QUOT_WIDTH-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_WIDTH'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    dsr_q  <= dsr_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  // last quotient bit is the rounding bit
  assign done_o = done_q;
  assign word_o = (dsr_q == '0) ? '0
                : quot_q[QUOT_WIDTH-1:1] + DATA_WIDTH'(quot_q[0]);

endmodule

@@ sim/dtw_write_monitor.sv @@
// dtw_write_monitor: channel monitor for the dds tuning word controller. It
// predicts the register writes from its own copy of the registers and multipliers
// and compares each one in order. Depends on dtw_pkg.
package dtw_tb_pkg;

  localparam logic CHIP_RF = 1'b0;
  localparam logic CHIP_LO = 1'b1;

endpackage

module dtw_write_monitor
  import dtw_pkg::*;
  import dtw_tb_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  in_req_t                   in_req_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  out_req_t                  out_req_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  logic [CLK_WIDTH-1:0]  ref_clk;
  logic [MULT_WIDTH-1:0] rf_ovr;
  logic [MULT_WIDTH-1:0] lo_ovr;
  logic [MULT_WIDTH-1:0] rf_mult;
  logic [MULT_WIDTH-1:0] lo_mult;
  out_req_t              exp_writes[$];

  function automatic logic [DATA_WIDTH-1:0] tuning_word_of(
    input logic [FREQ_WIDTH-1:0] f,
    input logic [DIV_WIDTH-1:0]  d
  );
    logic [63:0] rem;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] r;
    if (d == '0) begin
      return '0;
    end
    rem = 64'(f) % 64'(d);
    num = rem << 32;
    q   = num / 64'(d);
    r   = num % 64'(d);
    // round half up
    if ((r << 1) >= 64'(d)) begin
      q = q + 64'd1;
    end
    return q[DATA_WIDTH-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic predict_writes(input in_req_t req);
    logic [MULT_WIDTH-1:0] rf_new;
    logic [MULT_WIDTH-1:0] lo_new;
    logic [MULT_WIDTH-1:0] m;
    out_req_t              w;
    rf_new = rf_mult;
    lo_new = lo_mult;
    // automatic band selection
    if (req.channel == CHIP_RF && rf_ovr == '0 && lo_ovr == '0) begin
      if (req.freq_hz >= BAND_LOW && req.freq_hz <= BAND_HIGH) begin
        rf_new = RF_MULT_BAND;
        lo_new = LO_MULT_BAND;
      end else begin
        rf_new = RF_MULT_DEF;
        lo_new = LO_MULT_DEF;
      end
    end
    if (rf_ovr != '0 && lo_ovr != '0) begin
      rf_new = rf_ovr;
      lo_new = lo_ovr;
    end
    if (rf_new != rf_mult) begin
      rf_mult       = rf_new;
      w.target_chip = CHIP_RF;
      w.reg_addr    = REG_PLL;
      w.reg_data    = {24'd0, rf_new, PLL_CTL};
      w.last        = 1'b0;
      exp_writes.push_back(w);
    end
    if (lo_new != lo_mult) begin
      lo_mult       = lo_new;
      w.target_chip = CHIP_LO;
      w.reg_addr    = REG_PLL;
      w.reg_data    = {24'd0, lo_new, PLL_CTL};
      w.last        = 1'b0;
      exp_writes.push_back(w);
    end
    m             = (req.channel == CHIP_LO) ? lo_mult : rf_mult;
    w.target_chip = req.channel;
    w.reg_addr    = REG_FTW;
    w.reg_data    = tuning_word_of(req.freq_hz, DIV_WIDTH'(m) * DIV_WIDTH'(ref_clk));
    w.last        = 1'b1;
    exp_writes.push_back(w);
  endtask

  task automatic check_write(input out_req_t got);
    out_req_t want;
    if (exp_writes.size() == 0) begin
      report_mismatch($sformatf("unexpected request chip %0d reg %0d data %h last %0d",
                                got.target_chip, got.reg_addr, got.reg_data, got.last));
      return;
    end
    want = exp_writes.pop_front();
    if (got.target_chip !== want.target_chip) begin
      report_mismatch($sformatf("target_chip %0d, expected %0d",
                                got.target_chip, want.target_chip));
    end
    if (got.reg_addr !== want.reg_addr) begin
      report_mismatch($sformatf("reg_addr %0d, expected %0d", got.reg_addr, want.reg_addr));
    end
    if (got.reg_data !== want.reg_data) begin
      report_mismatch($sformatf("reg_data %h, expected %h (reg %0d)",
                                got.reg_data, want.reg_data, want.reg_addr));
    end
    if (got.last !== want.last) begin
      report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_clk = REF_CLK_RST;
      rf_ovr  = '0;
      lo_ovr  = '0;
      rf_mult = RF_MULT_DEF;
      lo_mult = LO_MULT_DEF;
      exp_writes.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_write(out_req_i);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_REF_CLK: ref_clk = cfg_wdata_i[CLK_WIDTH-1:0];
          CFG_RF_OVR:  rf_ovr  = cfg_wdata_i[MULT_WIDTH-1:0];
          CFG_LO_OVR:  lo_ovr  = cfg_wdata_i[MULT_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_writes(in_req_i);
      end
    end
    pending_o = exp_writes.size();
  end

endmodule

@@ sim/tb.sv @@
// tb: stimulus and verdict for dds_tuning_word_controller. Drives directed
// and random frequency requests across register settings with random idling.
// Depends on dtw_pkg, dtw_tb_pkg, dtw_write_monitor and the block itself.
module tb;
  import dtw_pkg::*;
  import dtw_tb_pkg::*;

  localparam int TIMEOUT_CYCLES = 500_000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  in_req_t                   in_req_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  out_req_t                  out_req_o;
  int                        fail_count;
  int                        pending;
  int                        gap_rate = 0;
  int                        stall_rate = 0;

  dds_tuning_word_controller i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  dtw_write_monitor i_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_req_i    (out_req_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("dds_tuning_word_controller verification failed");
    $finish;
  end

  // receiver stall bursts
  initial begin
    int stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_rate == 0) begin
        stall_left = 0;
      end else if (stall_left == 0 && $urandom_range(1, stall_rate * 4) == 1) begin
        stall_left = $urandom_range(1, 17);
      end
      out_stall_i = (stall_left != 0);
      if (stall_left != 0) begin
        stall_left--;
      end
    end
  end

  task automatic set_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                         input logic [CFG_DATA_WIDTH-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // entered and left at a falling edge; valid stays high after acceptance
  task automatic drive_req(input logic ch, input logic [FREQ_WIDTH-1:0] f);
    if (gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    in_req_i.channel = ch;
    in_req_i.freq_hz = f;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  initial begin
    logic                  ch;
    logic [FREQ_WIDTH-1:0] f;
    logic [CLK_WIDTH-1:0]  rc;
    logic [MULT_WIDTH-1:0] ro;
    logic [MULT_WIDTH-1:0] lo;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_REF_CLK;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: band edges and multiplier changes
    gap_rate   = 3;
    stall_rate = 2;
    drive_req(CHIP_RF, '0);
    drive_req(CHIP_RF, BAND_LOW);
    drive_req(CHIP_RF, BAND_HIGH);
    drive_req(CHIP_RF, BAND_HIGH + 1'b1);
    drive_req(CHIP_RF, BAND_LOW - 1'b1);
    drive_req(CHIP_LO, BAND_LOW);
    drive_req(CHIP_RF, '1);
    drive_req(CHIP_LO, '1);
    drive_req(CHIP_RF, FREQ_WIDTH'(64'd2211840000));
    drive_req(CHIP_LO, FREQ_WIDTH'(64'd700415999));

    // forced multipliers at the largest reference
    wait_idle();
    set_reg(CFG_REF_CLK, '1);
    set_reg(CFG_RF_OVR, CFG_DATA_WIDTH'(31));
    set_reg(CFG_LO_OVR, CFG_DATA_WIDTH'(1));
    drive_req(CHIP_LO, FREQ_WIDTH'(64'h2AAAAAAAA));
    drive_req(CHIP_RF, FREQ_WIDTH'(64'h155555555));
    drive_req(CHIP_RF, FREQ_WIDTH'(64'd4160749536));

    // one override zero keeps the multipliers
    wait_idle();
    set_reg(CFG_RF_OVR, '0);
    drive_req(CHIP_RF, BAND_LOW);
    drive_req(CHIP_LO, FREQ_WIDTH'(12345));

    // zero reference clock
    wait_idle();
    set_reg(CFG_REF_CLK, '0);
    set_reg(CFG_LO_OVR, '0);
    drive_req(CHIP_RF, FREQ_WIDTH'(700000000));
    drive_req(CHIP_LO, '1);

    // unit divisor
    wait_idle();
    set_reg(CFG_REF_CLK, CFG_DATA_WIDTH'(1));
    set_reg(CFG_RF_OVR, CFG_DATA_WIDTH'(1));
    set_reg(CFG_LO_OVR, CFG_DATA_WIDTH'(1));
    drive_req(CHIP_RF, '1);
    drive_req(CHIP_LO, FREQ_WIDTH'(5));

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case ($urandom_range(0, 11))
        0:       rc = CLK_WIDTH'(1);
        1:       rc = '1;
        2:       rc = '0;
        3, 4, 5: rc = REF_CLK_RST;
        default: rc = CLK_WIDTH'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          ro = '0;
          lo = '0;
        end
        3, 4: begin
          ro = MULT_WIDTH'($urandom_range(1, 31));
          lo = MULT_WIDTH'($urandom_range(1, 31));
        end
        default: begin
          ro = MULT_WIDTH'($urandom_range(1, 31));
          lo = '0;
          if ($urandom_range(0, 1) == 1) begin
            lo = ro;
            ro = '0;
          end
        end
      endcase
      set_reg(CFG_REF_CLK, CFG_DATA_WIDTH'(rc));
      set_reg(CFG_RF_OVR, CFG_DATA_WIDTH'(ro));
      set_reg(CFG_LO_OVR, CFG_DATA_WIDTH'(lo));
      if (ph == 7) begin
        gap_rate   = 0;
        stall_rate = 0;
      end else begin
        gap_rate   = $urandom_range(0, 3) * 3;
        stall_rate = $urandom_range(0, 3) * 2;
      end
      for (int k = 0; k < 50; k++) begin
        ch = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
          0, 1: f = FREQ_WIDTH'({$urandom, $urandom});
          2, 3: f = FREQ_WIDTH'($urandom_range(32'(BAND_LOW), 32'(BAND_HIGH)));
          4: begin
            case ($urandom_range(0, 3))
              0:       f = BAND_LOW - 1'b1;
              1:       f = BAND_LOW;
              2:       f = BAND_HIGH;
              default: f = BAND_HIGH + 1'b1;
            endcase
          end
          5:       f = FREQ_WIDTH'($urandom_range(0, 1_000_000));
          6:       f = '1 - FREQ_WIDTH'($urandom_range(0, 1000));
          default: f = FREQ_WIDTH'($urandom_range(0, 2_000_000_000));
        endcase
        drive_req(ch, f);
      end
    end

    in_valid_i = 1'b0;
    for (int n = 0; n < 20000 && pending != 0; n++) begin
      @(negedge clk_i);
    end
    repeat (200) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("dds_tuning_word_controller verification clean");
    end else begin
      $display("dds_tuning_word_controller verification failed");
    end
    $finish;
  end

endmodule
